>>> hdl/rrp_pkg.sv
// Shared constants and types of the rounded rectangle path generator.
// No dependencies; every other file of the block imports this package.
package rrp_pkg;

  localparam int COORD_BITS_DEFAULT = 24;

  localparam int CTRL_FACTOR = 29229;
  localparam int CTRL_ROUND  = 32768;
  localparam int CTRL_SHIFT  = 16;

  typedef enum logic [2:0] {
    KIND_EMPTY = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_LINE  = 3'd2,
    KIND_CURVE = 3'd3,
    KIND_CLOSE = 3'd4
  } seg_kind_t;

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_PLAIN,
    MODE_ROUND
  } path_mode_t;

endpackage

>>> hdl/rrp_rect_if.sv
// Input channel of the rounded rectangle path generator: one rectangle per beat.
// Depends on rrp_pkg for the default coordinate width.
interface rrp_rect_if
  import rrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic        [COORD_BITS-2:0] rect_width;
  logic        [COORD_BITS-2:0] rect_height;
  logic        [COORD_BITS-2:0] radius_x;
  logic        [COORD_BITS-2:0] radius_y;
  logic                         radius_x_given;
  logic                         radius_y_given;

  modport source (
    output valid, origin_x, origin_y, rect_width, rect_height,
           radius_x, radius_y, radius_x_given, radius_y_given,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, rect_width, rect_height,
           radius_x, radius_y, radius_x_given, radius_y_given,
    output ready
  );
endinterface

>>> hdl/rrp_seg_if.sv
// Output channel of the rounded rectangle path generator: one path segment per beat.
// Depends on rrp_pkg for the default coordinate width.
interface rrp_seg_if
  import rrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic                  [2:0]  segment_kind;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] ctrl1_x;
  logic signed [COORD_BITS-1:0] ctrl1_y;
  logic signed [COORD_BITS-1:0] ctrl2_x;
  logic signed [COORD_BITS-1:0] ctrl2_y;
  logic                         last_segment;

  modport source (
    output valid, segment_kind, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           last_segment,
    input  ready
  );

  modport sink (
    input  valid, segment_kind, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           last_segment,
    output ready
  );
endinterface

>>> hdl/rounded_rect_path_generator_unit.sv
// Top level of the rounded rectangle path generator.
// Depends on rrp_pkg and on the channel interfaces rrp_rect_if and rrp_seg_if.
//
// Usage: each beat on the rect channel carries one rectangle (origin, size, two
// corner radii and their given flags). The block answers on the seg channel with
// the outline path, one segment per beat, and marks the final segment of each
// path with last_segment. An empty rectangle gives a single segment of kind empty.
// A plain rectangle gives six segments, a rounded one six to ten.
// The first segment of a path passes through the input register, radius clamp,
// control offset multiply and job load before it reaches the output register,
// which sends one segment per cycle while seg.ready is high. The next rectangle
// moves through the front stages while the current path is being sent out.
// When the receiver holds ready low, the output register keeps its segment and
// the stages behind it fill and then hold; rect.ready falls once all are full.
// Reset clears every stage; no segment is valid after reset.
module rounded_rect_path_generator_unit
  import rrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  rrp_rect_if.sink  rect,
  rrp_seg_if.source seg
);

  localparam int SB = COORD_BITS - 1;
  localparam int MW = SB + CTRL_SHIFT + 1;

  localparam logic [3:0] RSLOT_MOVE   = 4'd0;
  localparam logic [3:0] RSLOT_CURVE0 = 4'd1;
  localparam logic [3:0] RSLOT_VLINE0 = 4'd2;
  localparam logic [3:0] RSLOT_CURVE1 = 4'd3;
  localparam logic [3:0] RSLOT_HLINE0 = 4'd4;
  localparam logic [3:0] RSLOT_CURVE2 = 4'd5;
  localparam logic [3:0] RSLOT_VLINE1 = 4'd6;
  localparam logic [3:0] RSLOT_CURVE3 = 4'd7;
  localparam logic [3:0] RSLOT_HLINE1 = 4'd8;
  localparam logic [3:0] RSLOT_CLOSE  = 4'd9;

  localparam logic [3:0] PSLOT_MOVE  = 4'd0;
  localparam logic [3:0] PSLOT_LINE0 = 4'd1;
  localparam logic [3:0] PSLOT_LINE1 = 4'd2;
  localparam logic [3:0] PSLOT_LINE2 = 4'd3;
  localparam logic [3:0] PSLOT_LINE3 = 4'd4;
  localparam logic [3:0] PSLOT_CLOSE = 4'd5;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SB-1:0]         size_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t xr;
    coord_t yb;
    coord_t xrx;
    coord_t yry;
    coord_t ybry;
    coord_t xrrx;
    coord_t xox;
    coord_t yoy;
    coord_t yboy;
    coord_t xrox;
  } coord_set_t;

  typedef struct packed {
    seg_kind_t kind;
    coord_t    ex;
    coord_t    ey;
    coord_t    c1x;
    coord_t    c1y;
    coord_t    c2x;
    coord_t    c2y;
    logic      last;
  } seg_t;

  // Input register.
  logic   a_valid;
  coord_t a_x, a_y;
  size_t  a_w, a_h, a_rx, a_ry;
  logic   a_xg, a_yg;

  // Radius clamp stage.
  logic   p_valid;
  coord_t p_x, p_y;
  size_t  p_w, p_h, p_rx, p_ry;
  logic   p_empty;

  // Control offset stage.
  logic       m_valid;
  coord_t     m_x, m_y, m_xr, m_yb;
  size_t      m_rx, m_ry, m_ox, m_oy;
  path_mode_t m_mode;
  logic       m_vl, m_hl;

  // Job register, stepped one segment per cycle while the output register is free.
  logic       j_valid;
  logic [3:0] j_step;
  logic [3:0] j_step_next;
  path_mode_t j_mode;
  logic       j_vl, j_hl;
  coord_set_t j_c;
  coord_set_t j_c_next;

  // Output register.
  logic o_valid;
  seg_t o_seg;
  seg_t seg_cur;

  logic  o_free, j_emit, j_last, j_load_ok, m_ok, p_ok;
  size_t rsel_x, rsel_y, half_w, half_h, rx_c, ry_c;
  logic  [MW-1:0] prod_x, prod_y;

  assign o_free    = !o_valid || seg.ready;
  assign j_emit    = j_valid && o_free;
  assign j_load_ok = !j_valid || (o_free && j_last);
  assign m_ok      = !m_valid || j_load_ok;
  assign p_ok      = !p_valid || m_ok;
  assign rect.ready = !rst && (!a_valid || p_ok);

  always_comb begin
    half_w = a_w >> 1;
    half_h = a_h >> 1;
    rsel_x = a_xg ? a_rx : a_ry;
    rsel_y = a_yg ? a_ry : a_rx;
    if (!(a_xg || a_yg)) begin
      rx_c = '0;
      ry_c = '0;
    end else begin
      rx_c = (rsel_x > half_w) ? half_w : rsel_x;
      ry_c = (rsel_y > half_h) ? half_h : rsel_y;
    end
  end

  assign prod_x = MW'(p_rx) * MW'(CTRL_FACTOR) + MW'(CTRL_ROUND);
  assign prod_y = MW'(p_ry) * MW'(CTRL_FACTOR) + MW'(CTRL_ROUND);

  always_comb begin
    j_c_next.x    = m_x;
    j_c_next.y    = m_y;
    j_c_next.xr   = m_xr;
    j_c_next.yb   = m_yb;
    j_c_next.xrx  = m_x + COORD_BITS'(m_rx);
    j_c_next.yry  = m_y + COORD_BITS'(m_ry);
    j_c_next.ybry = m_yb - COORD_BITS'(m_ry);
    j_c_next.xrrx = m_xr - COORD_BITS'(m_rx);
    j_c_next.xox  = m_x + COORD_BITS'(m_ox);
    j_c_next.yoy  = m_y + COORD_BITS'(m_oy);
    j_c_next.yboy = m_yb - COORD_BITS'(m_oy);
    j_c_next.xrox = m_xr - COORD_BITS'(m_ox);
  end

  always_comb begin
    unique case (j_mode)
      MODE_EMPTY: j_last = 1'b1;
      MODE_PLAIN: j_last = (j_step == PSLOT_CLOSE);
      MODE_ROUND: j_last = (j_step == RSLOT_CLOSE);
      default:    j_last = 1'b1;
    endcase
  end

  always_comb begin
    j_step_next = j_step + 4'd1;
    if (j_mode == MODE_ROUND) begin
      case (j_step + 4'd1) inside
        RSLOT_VLINE0, RSLOT_VLINE1: if (!j_vl) j_step_next = j_step + 4'd2;
        RSLOT_HLINE0, RSLOT_HLINE1: if (!j_hl) j_step_next = j_step + 4'd2;
        default: ;
      endcase
    end
  end

  always_comb begin
    seg_cur      = '0;
    seg_cur.kind = KIND_EMPTY;
    seg_cur.last = j_last;
    unique case (j_mode)
      MODE_EMPTY: ;
      MODE_PLAIN: begin
        case (j_step)
          PSLOT_MOVE: begin
            seg_cur.kind = KIND_MOVE;
            seg_cur.ex = j_c.x;  seg_cur.ey = j_c.y;
          end
          PSLOT_LINE0: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.x;  seg_cur.ey = j_c.yb;
          end
          PSLOT_LINE1: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.xr; seg_cur.ey = j_c.yb;
          end
          PSLOT_LINE2: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.xr; seg_cur.ey = j_c.y;
          end
          PSLOT_LINE3: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.x;  seg_cur.ey = j_c.y;
          end
          default: begin
            seg_cur.kind = KIND_CLOSE;
            seg_cur.ex = j_c.x;  seg_cur.ey = j_c.y;
          end
        endcase
      end
      MODE_ROUND: begin
        case (j_step)
          RSLOT_MOVE: begin
            seg_cur.kind = KIND_MOVE;
            seg_cur.ex = j_c.xrx; seg_cur.ey = j_c.y;
          end
          RSLOT_CURVE0: begin
            seg_cur.kind = KIND_CURVE;
            seg_cur.ex  = j_c.x;    seg_cur.ey  = j_c.yry;
            seg_cur.c1x = j_c.xox;  seg_cur.c1y = j_c.y;
            seg_cur.c2x = j_c.x;    seg_cur.c2y = j_c.yoy;
          end
          RSLOT_VLINE0: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.x;    seg_cur.ey = j_c.ybry;
          end
          RSLOT_CURVE1: begin
            seg_cur.kind = KIND_CURVE;
            seg_cur.ex  = j_c.xrx;  seg_cur.ey  = j_c.yb;
            seg_cur.c1x = j_c.x;    seg_cur.c1y = j_c.yboy;
            seg_cur.c2x = j_c.xox;  seg_cur.c2y = j_c.yb;
          end
          RSLOT_HLINE0: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.xrrx; seg_cur.ey = j_c.yb;
          end
          RSLOT_CURVE2: begin
            seg_cur.kind = KIND_CURVE;
            seg_cur.ex  = j_c.xr;   seg_cur.ey  = j_c.ybry;
            seg_cur.c1x = j_c.xrox; seg_cur.c1y = j_c.yb;
            seg_cur.c2x = j_c.xr;   seg_cur.c2y = j_c.yboy;
          end
          RSLOT_VLINE1: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.xr;   seg_cur.ey = j_c.yry;
          end
          RSLOT_CURVE3: begin
            seg_cur.kind = KIND_CURVE;
            seg_cur.ex  = j_c.xrrx; seg_cur.ey  = j_c.y;
            seg_cur.c1x = j_c.xr;   seg_cur.c1y = j_c.yoy;
            seg_cur.c2x = j_c.xrox; seg_cur.c2y = j_c.y;
          end
          RSLOT_HLINE1: begin
            seg_cur.kind = KIND_LINE;
            seg_cur.ex = j_c.xrx;  seg_cur.ey = j_c.y;
          end
          default: begin
            seg_cur.kind = KIND_CLOSE;
            seg_cur.ex = j_c.xrx;  seg_cur.ey = j_c.y;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
      j_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (rect.ready) a_valid <= rect.valid;
      if (p_ok)       p_valid <= a_valid;
      if (m_ok)       m_valid <= p_valid;
      if (j_load_ok)  j_valid <= m_valid;
      if (o_free)     o_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rect.ready && rect.valid) begin
      a_x  <= rect.origin_x;
      a_y  <= rect.origin_y;
      a_w  <= rect.rect_width;
      a_h  <= rect.rect_height;
      a_rx <= rect.radius_x;
      a_ry <= rect.radius_y;
      a_xg <= rect.radius_x_given;
      a_yg <= rect.radius_y_given;
    end
    if (p_ok && a_valid) begin
      p_x     <= a_x;
      p_y     <= a_y;
      p_w     <= a_w;
      p_h     <= a_h;
      p_rx    <= rx_c;
      p_ry    <= ry_c;
      p_empty <= (a_w == '0) || (a_h == '0);
    end
    if (m_ok && p_valid) begin
      m_x  <= p_x;
      m_y  <= p_y;
      m_xr <= p_x + COORD_BITS'(p_w);
      m_yb <= p_y + COORD_BITS'(p_h);
      m_rx <= p_rx;
      m_ry <= p_ry;
      m_ox <= prod_x[CTRL_SHIFT +: SB];
      m_oy <= prod_y[CTRL_SHIFT +: SB];
      m_vl <= {p_ry, 1'b0} < {1'b0, p_h};
      m_hl <= {p_rx, 1'b0} < {1'b0, p_w};
      if (p_empty) begin
        m_mode <= MODE_EMPTY;
      end else if ((p_rx != '0) && (p_ry != '0)) begin
        m_mode <= MODE_ROUND;
      end else begin
        m_mode <= MODE_PLAIN;
      end
    end
    if (j_load_ok && m_valid) begin
      j_step <= '0;
      j_mode <= m_mode;
      j_vl   <= m_vl;
      j_hl   <= m_hl;
      j_c    <= j_c_next;
    end else if (j_emit) begin
      j_step <= j_step_next;
    end
    if (j_emit) begin
      o_seg <= seg_cur;
    end
  end

  assign seg.valid        = o_valid;
  assign seg.segment_kind = o_seg.kind;
  assign seg.end_x        = o_seg.ex;
  assign seg.end_y        = o_seg.ey;
  assign seg.ctrl1_x      = o_seg.c1x;
  assign seg.ctrl1_y      = o_seg.c1y;
  assign seg.ctrl2_x      = o_seg.c2x;
  assign seg.ctrl2_y      = o_seg.c2y;
  assign seg.last_segment = o_seg.last;

  a_close_is_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_seg.kind == KIND_CLOSE || o_seg.kind == KIND_EMPTY) |-> o_seg.last)
    else $error("close or empty segment without last_segment");

  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_seg.kind == KIND_MOVE |-> !o_seg.last)
    else $error("move segment marked as last");

  a_round_step_range: assert property (@(posedge clk) disable iff (rst)
    j_valid && j_mode == MODE_ROUND |-> j_step <= RSLOT_CLOSE)
    else $error("rounded path step out of range");

  a_plain_step_range: assert property (@(posedge clk) disable iff (rst)
    j_valid && j_mode == MODE_PLAIN |-> j_step <= PSLOT_CLOSE)
    else $error("plain path step out of range");

endmodule
